// ----- hw/rtl/tabu_search_variable_pick_macros.svh -----
// Assertion macros for the tabu search variable pick block
`ifndef TABU_SEARCH_VARIABLE_PICK_MACROS_SVH
`define TABU_SEARCH_VARIABLE_PICK_MACROS_SVH
`ifndef SYNTHESIS
`define TSVP_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");
`define TSVP_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`else
`define TSVP_ASSERT(lbl, cond)
`define TSVP_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ----- hw/rtl/tsvp_pkg.sv -----
// Shared constants, codes and controller/datapath interface types
package tsvp_pkg;
	localparam int MAX_VARS = 1024;
	localparam int IDX_W    = $clog2(MAX_VARS);
	localparam int VAR_W    = 11;
	localparam int SCORE_W  = 16;
	localparam int UNSAT_W  = 16;
	localparam int ITER_W   = 32;
	localparam int TEN_W    = 10;
	localparam int FAC_W    = 10;
	localparam int LIM_W    = FAC_W + VAR_W;
	localparam int Q_W      = UNSAT_W + 2;

	localparam logic [1:0] FUNC_WRITE  = 2'd0;
	localparam logic [1:0] FUNC_SELECT = 2'd1;
	localparam logic [1:0] FUNC_CLEAR  = 2'd2;

	localparam logic [1:0] CFG_NUM_VARS = 2'd0;
	localparam logic [1:0] CFG_TENURE   = 2'd1;
	localparam logic [1:0] CFG_FACTOR   = 2'd2;

	localparam logic [1:0] CAUSE_ASP  = 2'd0;
	localparam logic [1:0] CAUSE_STAG = 2'd1;
	localparam logic [1:0] CAUSE_BEST = 2'd2;
	localparam logic [1:0] CAUSE_NONE = 2'd3;

	localparam logic [VAR_W-1:0] RST_NUM_VARS = 11'd1024;
	localparam logic [TEN_W-1:0] RST_TENURE   = 10'd10;
	localparam logic [FAC_W-1:0] RST_FACTOR   = 10'd10;

	typedef struct packed {
		logic       div_start;
		logic       div_tie;
		logic       asp_rd;
		logic       asp_chk;
		logic       scan_init;
		logic       scan_run;
		logic       list_rd;
		logic       list_set;
		logic       clr_wr;
		logic       out_load;
		logic [1:0] cause;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic div_done;
		logic score_pos;
		logic scan_hit;
		logic scan_done;
		logic cand_any;
		logic out_busy;
	} status_t;
endpackage

// ----- hw/rtl/tsvp_mod.sv -----
// Restoring remainder unit, one dividend bit per cycle
module tsvp_mod (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [tsvp_pkg::ITER_W-1:0] dividend,
	input  logic [tsvp_pkg::VAR_W-1:0]  divisor,
	output logic                       done,
	output logic [tsvp_pkg::VAR_W-1:0]  rem
);
	import tsvp_pkg::*;

	localparam int CNT_W = $clog2(ITER_W + 1);

	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [ITER_W-1:0] dvd_q;
	logic [VAR_W-1:0]  div_q;
	logic [VAR_W-1:0]  rem_q;
	logic [VAR_W:0]    trial;
	logic [VAR_W:0]    diff;

	assign trial = {rem_q, dvd_q[ITER_W-1]};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(ITER_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[ITER_W-2:0], 1'b0};
			if (trial >= {1'b0, div_q}) rem_q <= diff[VAR_W-1:0];
			else rem_q <= trial[VAR_W-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;
endmodule

// ----- hw/rtl/tsvp_dp.sv -----
// Datapath: config, score/tabu/candidate memories, scan and result registers
`include "tabu_search_variable_pick_macros.svh"
module tsvp_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tsvp_pkg::cmd_t               cmd,
	output tsvp_pkg::status_t            sts,
	input  logic                         cfg_we,
	input  logic [1:0]                   cfg_index,
	input  logic [tsvp_pkg::VAR_W-1:0]    cfg_data,
	input  logic                         in_accept,
	input  logic [1:0]                   func,
	input  logic [tsvp_pkg::VAR_W-1:0]    var_index,
	input  logic signed [tsvp_pkg::SCORE_W-1:0] score,
	input  logic [tsvp_pkg::UNSAT_W-1:0]  unsat_count,
	input  logic [tsvp_pkg::ITER_W-1:0]   iteration,
	input  logic [tsvp_pkg::ITER_W-1:0]   rand_pick,
	input  logic [tsvp_pkg::ITER_W-1:0]   rand_tie,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         found,
	output logic [tsvp_pkg::VAR_W-1:0]    chosen_var,
	output logic [1:0]                   cause
);
	import tsvp_pkg::*;

	logic [VAR_W-1:0]   num_vars_q;
	logic [TEN_W-1:0]   tenure_q;
	logic [FAC_W-1:0]   factor_q;
	logic [VAR_W-1:0]   n;
	logic [LIM_W-1:0]   limit_q;

	logic [UNSAT_W-1:0] unsat_q;
	logic [ITER_W-1:0]  iter_q;
	logic [ITER_W-1:0]  rpick_q;
	logic [ITER_W-1:0]  rtie_q;

	logic [SCORE_W-1:0] score_mem [MAX_VARS];
	logic [ITER_W-1:0]  tabu_mem  [MAX_VARS];
	logic [IDX_W-1:0]   list_mem  [MAX_VARS];

	logic [SCORE_W-1:0] score_rd_q;
	logic [ITER_W-1:0]  tabu_rd_q;
	logic [IDX_W-1:0]   list_rd_q;
	logic [IDX_W-1:0]   rd_addr;

	logic [ITER_W-1:0]  stag_bound_q;
	logic [ITER_W-1:0]  tabu_bound_q;
	logic               stag_en_q;
	logic signed [Q_W-1:0] best_q;
	logic [VAR_W-1:0]   count_q;
	logic [VAR_W-1:0]   iss_q;
	logic               issuing;
	logic               v_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic [IDX_W-1:0]   clr_cnt_q;

	logic               hit;
	logic               elig;
	logic signed [Q_W-1:0] q;
	logic               lower;
	logic               tie;

	logic [VAR_W-1:0]   res_var_q;
	logic               out_valid_q;
	logic               found_q;
	logic [VAR_W-1:0]   chosen_q;
	logic [1:0]         cause_q;

	logic               div_done;
	logic [VAR_W-1:0]   div_rem;

	logic [IDX_W-1:0]   tabu_wa;
	logic [ITER_W-1:0]  tabu_wd;
	logic               tabu_we;

	always_comb begin
		if (num_vars_q == '0) n = VAR_W'(1);
		else if (num_vars_q > VAR_W'(MAX_VARS)) n = VAR_W'(MAX_VARS);
		else n = num_vars_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_vars_q <= RST_NUM_VARS;
			tenure_q   <= RST_TENURE;
			factor_q   <= RST_FACTOR;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NUM_VARS: num_vars_q <= cfg_data;
				CFG_TENURE:   tenure_q   <= cfg_data[TEN_W-1:0];
				CFG_FACTOR:   factor_q   <= cfg_data[FAC_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		limit_q <= LIM_W'(factor_q) * LIM_W'(n);
		if (in_accept) begin
			unsat_q <= unsat_count;
			iter_q  <= iteration;
			rpick_q <= rand_pick;
			rtie_q  <= rand_tie;
		end
	end

	tsvp_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (cmd.div_tie ? rtie_q : rpick_q),
		.divisor  (cmd.div_tie ? count_q : n),
		.done     (div_done),
		.rem      (div_rem)
	);

	assign rd_addr = cmd.asp_rd ? div_rem[IDX_W-1:0] : iss_q[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (in_accept && func == FUNC_WRITE && var_index != '0
			&& var_index <= VAR_W'(MAX_VARS)) begin
			score_mem[IDX_W'(var_index - 1'b1)] <= score;
		end
		score_rd_q <= score_mem[rd_addr];
	end

	assign tabu_we = cmd.clr_wr || hit;
	assign tabu_wa = cmd.clr_wr ? clr_cnt_q : idx_s1;
	assign tabu_wd = cmd.clr_wr ? '0 : iter_q;

	always_ff @(posedge clk) begin
		if (tabu_we) tabu_mem[tabu_wa] <= tabu_wd;
		tabu_rd_q <= tabu_mem[iss_q[IDX_W-1:0]];
	end

	assign issuing = iss_q < n;
	assign hit     = cmd.scan_run && v_s1 && stag_en_q && (tabu_rd_q < stag_bound_q);
	assign elig    = tabu_rd_q < tabu_bound_q;
	assign q       = $signed({2'b00, unsat_q}) - $signed({{2{score_rd_q[SCORE_W-1]}}, score_rd_q});
	assign lower   = cmd.scan_run && v_s1 && !hit && elig && (q < best_q);
	assign tie     = cmd.scan_run && v_s1 && !hit && elig && (q == best_q)
		&& (count_q < VAR_W'(MAX_VARS));

	always_ff @(posedge clk) begin
		if (lower) list_mem[0] <= idx_s1;
		else if (tie) list_mem[count_q[IDX_W-1:0]] <= idx_s1;
		if (cmd.list_rd) list_rd_q <= list_mem[div_rem[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			iss_q     <= '0;
			v_s1      <= 1'b0;
			clr_cnt_q <= '0;
		end else begin
			if (cmd.clr_wr) clr_cnt_q <= clr_cnt_q + 1'b1;
			if (cmd.scan_init) begin
				count_q <= '0;
				iss_q   <= '0;
				v_s1    <= 1'b0;
			end else if (cmd.scan_run) begin
				if (issuing) iss_q <= iss_q + 1'b1;
				v_s1 <= issuing;
				if (lower) count_q <= VAR_W'(1);
				else if (tie) count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= iss_q[IDX_W-1:0];
		if (cmd.scan_init) begin
			stag_bound_q <= iter_q - ITER_W'(limit_q);
			tabu_bound_q <= iter_q - ITER_W'(tenure_q);
			stag_en_q    <= iter_q > ITER_W'(limit_q);
			best_q       <= $signed({2'b00, unsat_q});
		end else if (lower) begin
			best_q <= q;
		end
		if (cmd.asp_chk) res_var_q <= div_rem + 1'b1;
		else if (hit) res_var_q <= VAR_W'(idx_s1) + 1'b1;
		else if (cmd.list_set) res_var_q <= VAR_W'(list_rd_q) + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			found_q  <= cmd.cause != CAUSE_NONE;
			chosen_q <= (cmd.cause == CAUSE_NONE) ? '0 : res_var_q;
			cause_q  <= cmd.cause;
		end
	end

	assign out_valid  = out_valid_q;
	assign found      = found_q;
	assign chosen_var = chosen_q;
	assign cause      = cause_q;

	assign sts.clr_last  = clr_cnt_q == IDX_W'(MAX_VARS - 1);
	assign sts.div_done  = div_done;
	assign sts.score_pos = $signed(score_rd_q) > 0;
	assign sts.scan_hit  = hit;
	assign sts.scan_done = cmd.scan_run && v_s1 && !hit && (VAR_W'(idx_s1) == n - 1'b1);
	assign sts.cand_any  = count_q != '0;
	assign sts.out_busy  = out_valid_q && !out_ready;

	`TSVP_ASSERT(a_count_max, count_q <= VAR_W'(MAX_VARS))
	`TSVP_ASSERT_NEXT(a_out_load, cmd.out_load, out_valid_q)
	`TSVP_ASSERT(a_list_idx, !cmd.list_rd || div_rem < count_q)
	`TSVP_ASSERT(a_no_clr_in_scan, !(cmd.clr_wr && cmd.scan_run))
endmodule

// ----- hw/rtl/tsvp_ctrl.sv -----
// Controller state machine sequencing clear, aspiration, scan and tie pick
module tsvp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [1:0]        func,
	output logic              in_ready,
	output tsvp_pkg::cmd_t    cmd,
	input  tsvp_pkg::status_t sts
);
	import tsvp_pkg::*;

	typedef enum logic [3:0] {
		ST_CLR, ST_IDLE, ST_DIVP_GO, ST_DIVP, ST_ASP_RD, ST_ASP_CHK,
		ST_SCAN_INIT, ST_SCAN, ST_SCAN_END, ST_DIVT_GO, ST_DIVT,
		ST_LIST_RD, ST_LIST_SET, ST_EMIT
	} state_t;

	state_t     state_q;
	logic [1:0] cause_q;

	assign in_ready = state_q == ST_IDLE;

	always_comb begin
		cmd           = '0;
		cmd.cause     = cause_q;
		cmd.div_tie   = state_q == ST_DIVT_GO;
		cmd.div_start = state_q == ST_DIVP_GO || state_q == ST_DIVT_GO;
		cmd.asp_rd    = state_q == ST_ASP_RD;
		cmd.asp_chk   = state_q == ST_ASP_CHK;
		cmd.scan_init = state_q == ST_SCAN_INIT;
		cmd.scan_run  = state_q == ST_SCAN;
		cmd.list_rd   = state_q == ST_LIST_RD;
		cmd.list_set  = state_q == ST_LIST_SET;
		cmd.clr_wr    = state_q == ST_CLR;
		cmd.out_load  = state_q == ST_EMIT && !sts.out_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			cause_q <= CAUSE_NONE;
		end else begin
			unique case (state_q)
				ST_CLR:
					if (sts.clr_last) state_q <= ST_IDLE;
				ST_IDLE:
					if (in_valid) begin
						if (func == FUNC_SELECT) state_q <= ST_DIVP_GO;
						else if (func == FUNC_CLEAR) state_q <= ST_CLR;
					end
				ST_DIVP_GO: state_q <= ST_DIVP;
				ST_DIVP:
					if (sts.div_done) state_q <= ST_ASP_RD;
				ST_ASP_RD: state_q <= ST_ASP_CHK;
				ST_ASP_CHK:
					if (sts.score_pos) begin
						cause_q <= CAUSE_ASP;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_SCAN_INIT;
					end
				ST_SCAN_INIT: state_q <= ST_SCAN;
				ST_SCAN:
					if (sts.scan_hit) begin
						cause_q <= CAUSE_STAG;
						state_q <= ST_EMIT;
					end else if (sts.scan_done) begin
						state_q <= ST_SCAN_END;
					end
				ST_SCAN_END:
					if (sts.cand_any) begin
						state_q <= ST_DIVT_GO;
					end else begin
						cause_q <= CAUSE_NONE;
						state_q <= ST_EMIT;
					end
				ST_DIVT_GO: state_q <= ST_DIVT;
				ST_DIVT:
					if (sts.div_done) state_q <= ST_LIST_RD;
				ST_LIST_RD: state_q <= ST_LIST_SET;
				ST_LIST_SET: begin
					cause_q <= CAUSE_BEST;
					state_q <= ST_EMIT;
				end
				ST_EMIT:
					if (!sts.out_busy) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ----- hw/rtl/tabu_search_variable_pick.sv -----
// Top level of the tabu search variable pick block
//
// Input channel (in_valid/in_ready) takes one beat per item: func selects
// write score, select variable or clear tabu store. The output channel
// (out_valid/out_ready) carries one beat per select: found, chosen_var, cause.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data).
// A write score item leaves the block ready for the next item. A clear item
// sweeps the 1024-entry tabu memory, one entry a cycle. A select item draws
// a random variable and emits it if its score is positive (aspiration);
// else it scans the variables, ending early on a stagnant one, or draws a
// tie pick among the best candidates. The scan is serial over the score and
// tabu memories, one variable a cycle; draws use the 32-step remainder unit.
// After reset the tabu memory is cleared the same way and in_ready stays
// low meanwhile; configuration writes are taken at any time.
// A finished result sits in the output register; if the receiver stalls, the
// block holds the beat and takes further write and clear items, and a new
// select waits at its end until the output register is free.
module tabu_search_variable_pick (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [1:0]                         cfg_index,
	input  logic [tsvp_pkg::VAR_W-1:0]          cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [1:0]                         func,
	input  logic [tsvp_pkg::VAR_W-1:0]          var_index,
	input  logic signed [tsvp_pkg::SCORE_W-1:0] score,
	input  logic [tsvp_pkg::UNSAT_W-1:0]        unsat_count,
	input  logic [tsvp_pkg::ITER_W-1:0]         iteration,
	input  logic [tsvp_pkg::ITER_W-1:0]         rand_pick,
	input  logic [tsvp_pkg::ITER_W-1:0]         rand_tie,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               found,
	output logic [tsvp_pkg::VAR_W-1:0]          chosen_var,
	output logic [1:0]                         cause
);
	import tsvp_pkg::*;

	cmd_t    cmd;
	status_t sts;
	logic    in_accept;

	assign in_accept = in_valid && in_ready;

	tsvp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.func     (func),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	tsvp_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_accept   (in_accept),
		.func        (func),
		.var_index   (var_index),
		.score       (score),
		.unsat_count (unsat_count),
		.iteration   (iteration),
		.rand_pick   (rand_pick),
		.rand_tie    (rand_tie),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.found       (found),
		.chosen_var  (chosen_var),
		.cause       (cause)
	);
endmodule
